@@ rtl/u8sv_pkg.sv @@
// types and constants shared by the utf-8 stream validator
`timescale 1ns / 1ps
`default_nettype none
package u8sv_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [2:0]  error_kind;
    logic [15:0] error_position;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_ZERO      = 3'd1,
    KIND_BAD_LEAD  = 3'd2,
    KIND_TRUNCATED = 3'd3,
    KIND_BAD_CONT  = 3'd4,
    KIND_OVERLONG  = 3'd5,
    KIND_ABOVE_MAX = 3'd6,
    KIND_SURROGATE = 3'd7
  } err_kind_t;

  // minimum decoded value class of an open sequence
  localparam logic [1:0] CLASS_MIN_80    = 2'd0;
  localparam logic [1:0] CLASS_MIN_800   = 2'd1;
  localparam logic [1:0] CLASS_MIN_10000 = 2'd2;

  localparam logic [7:0] ASCII_TOP = 8'h7f;
  localparam logic [7:0] LEAD2_LO  = 8'hc2;
  localparam logic [7:0] LEAD2_HI  = 8'hdf;
  localparam logic [7:0] LEAD3_LO  = 8'he0;
  localparam logic [7:0] LEAD3_HI  = 8'hef;
  localparam logic [7:0] LEAD4_LO  = 8'hf0;
  localparam logic [7:0] LEAD4_HI  = 8'hf4;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  localparam logic [20:0] MIN_2B   = 21'h00080;
  localparam logic [20:0] MIN_3B   = 21'h00800;
  localparam logic [20:0] MIN_4B   = 21'h10000;
  localparam logic [20:0] CODE_MAX = 21'h10ffff;
  localparam logic [20:0] SURR_LO  = 21'h0d800;
  localparam logic [20:0] SURR_HI  = 21'h0dfff;

endpackage
`default_nettype wire

@@ rtl/utf8_stream_validator.sv @@
// utf8_stream_validator: strict utf-8 check of a byte string, verdict on its last byte
//
// input channel: one byte per transaction (in_item.data_byte) with in_item.last set on
// the final byte of a string. every string has at least one byte.
// result channel: one transaction per string, issued for its last byte: valid_res,
// the kind of the first error and its byte index (0 and 0 when the string is clean).
// a last byte is held in the input register, then the decode/state update writes the
// result register. throughput: one byte per cycle while in_stall is low; the sequence
// state update is a single pass of narrow compares and a 21-bit range check between the
// input and result registers.
// a stalled result holds in the output register; bytes that do not end a string keep
// flowing past it, and only a last byte waits in the input register for it to drain.
// in_stall rises only while the input register holds a byte it cannot pass on.
// reset (rst_n low, synchronous) empties both registers and clears the sequence,
// error and position state; no clearing pass is needed.
// byte positions count modulo 2**POSITION_BITS; error_position shows the low 16 bits.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_validator #(
  parameter int POSITION_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire u8sv_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output u8sv_pkg::out_item_t  out_item
);

  localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  // input register
  logic                in_valid_r;
  u8sv_pkg::in_item_t  in_item_r;

  // sequence and error state
  logic [1:0]               pend_r, pend_nxt;
  logic [20:0]              code_r, code_nxt;
  logic [1:0]               class_r, class_nxt;
  logic                     err_r, err_nxt;
  u8sv_pkg::err_kind_t      kind_r, kind_nxt;
  logic [POSITION_BITS-1:0] epos_r, epos_nxt;
  logic [POSITION_BITS-1:0] bpos_r, bpos_nxt;

  // result register
  logic                 out_valid_r;
  u8sv_pkg::out_item_t  out_item_r, out_item_nxt;

  logic out_free;
  logic proc_go;
  logic [15:0] epos_16;

  assign out_free = !out_valid_r || !out_stall;
  // a byte that ends a string needs room in the result register
  assign proc_go  = in_valid_r && (!in_item_r.last || out_free);
  assign in_stall = in_valid_r && !proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [20:0] shifted;
    logic [20:0] lowest;
    logic        rec;
    u8sv_pkg::err_kind_t rec_kind;

    b         = in_item_r.data_byte;
    shifted   = {code_r[14:0], b[5:0]};
    lowest    = u8sv_pkg::MIN_2B;
    rec       = 1'b0;
    rec_kind  = u8sv_pkg::KIND_NONE;
    pend_nxt  = pend_r;
    code_nxt  = code_r;
    class_nxt = class_r;

    case (class_r)
      u8sv_pkg::CLASS_MIN_800:   lowest = u8sv_pkg::MIN_3B;
      u8sv_pkg::CLASS_MIN_10000: lowest = u8sv_pkg::MIN_4B;
      default:                   lowest = u8sv_pkg::MIN_2B;
    endcase

    if (!err_r) begin
      if (pend_r != 2'd0) begin
        if (b[7:6] != u8sv_pkg::CONT_TAG) begin
          rec      = 1'b1;
          rec_kind = u8sv_pkg::KIND_BAD_CONT;
        end else begin
          code_nxt = shifted;
          pend_nxt = pend_r - 2'd1;
          // sequence complete: range checks on the decoded value
          if (pend_r == 2'd1) begin
            if (shifted < lowest) begin
              rec      = 1'b1;
              rec_kind = u8sv_pkg::KIND_OVERLONG;
            end else if (shifted > u8sv_pkg::CODE_MAX) begin
              rec      = 1'b1;
              rec_kind = u8sv_pkg::KIND_ABOVE_MAX;
            end else if (shifted >= u8sv_pkg::SURR_LO && shifted <= u8sv_pkg::SURR_HI) begin
              rec      = 1'b1;
              rec_kind = u8sv_pkg::KIND_SURROGATE;
            end
          end
        end
      end else if (b == 8'd0) begin
        rec      = 1'b1;
        rec_kind = u8sv_pkg::KIND_ZERO;
      end else if (b <= u8sv_pkg::ASCII_TOP) begin
        pend_nxt = 2'd0;
      end else if (b >= u8sv_pkg::LEAD2_LO && b <= u8sv_pkg::LEAD2_HI) begin
        pend_nxt  = 2'd1;
        code_nxt  = {16'd0, b[4:0]};
        class_nxt = u8sv_pkg::CLASS_MIN_80;
      end else if (b >= u8sv_pkg::LEAD3_LO && b <= u8sv_pkg::LEAD3_HI) begin
        pend_nxt  = 2'd2;
        code_nxt  = {17'd0, b[3:0]};
        class_nxt = u8sv_pkg::CLASS_MIN_800;
      end else if (b >= u8sv_pkg::LEAD4_LO && b <= u8sv_pkg::LEAD4_HI) begin
        pend_nxt  = 2'd3;
        code_nxt  = {18'd0, b[2:0]};
        class_nxt = u8sv_pkg::CLASS_MIN_10000;
      end else begin
        rec      = 1'b1;
        rec_kind = u8sv_pkg::KIND_BAD_LEAD;
      end
    end

    // open sequence at the end of the string
    if (in_item_r.last && !err_r && !rec && pend_nxt != 2'd0) begin
      rec      = 1'b1;
      rec_kind = u8sv_pkg::KIND_TRUNCATED;
    end

    err_nxt  = err_r;
    kind_nxt = kind_r;
    epos_nxt = epos_r;
    if (rec) begin
      err_nxt  = 1'b1;
      kind_nxt = rec_kind;
      epos_nxt = bpos_r;
    end
    bpos_nxt = bpos_r + POS_ONE;
  end

  generate
    if (POSITION_BITS >= 16) begin : g_pos_trunc
      assign epos_16 = epos_nxt[15:0];
    end else begin : g_pos_ext
      assign epos_16 = {{(16-POSITION_BITS){1'b0}}, epos_nxt};
    end
  endgenerate

  always_comb begin
    out_item_nxt.valid_res      = !err_nxt;
    out_item_nxt.error_kind     = err_nxt ? kind_nxt : u8sv_pkg::KIND_NONE;
    out_item_nxt.error_position = err_nxt ? epos_16 : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 2'd0;
      code_r  <= 21'd0;
      class_r <= u8sv_pkg::CLASS_MIN_80;
      err_r   <= 1'b0;
      kind_r  <= u8sv_pkg::KIND_NONE;
      epos_r  <= '0;
      bpos_r  <= '0;
    end else if (proc_go) begin
      if (in_item_r.last) begin
        // verdict given, state returns to its start for the next string
        pend_r  <= 2'd0;
        code_r  <= 21'd0;
        class_r <= u8sv_pkg::CLASS_MIN_80;
        err_r   <= 1'b0;
        kind_r  <= u8sv_pkg::KIND_NONE;
        epos_r  <= '0;
        bpos_r  <= '0;
      end else begin
        pend_r  <= pend_nxt;
        code_r  <= code_nxt;
        class_r <= class_nxt;
        err_r   <= err_nxt;
        kind_r  <= kind_nxt;
        epos_r  <= epos_nxt;
        bpos_r  <= bpos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go && in_item_r.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && in_item_r.last) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

@@ test/utf8_stream_validator_tb.sv @@
// testbench for the strict utf-8 stream validator: directed strings, long strings, random strings
`timescale 1ns / 1ps
module utf8_stream_validator_tb;

  typedef logic [7:0] byte_str_t[$];

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  u8sv_pkg::in_item_t in_item = '0;
  logic in_stall;
  logic out_valid;
  u8sv_pkg::out_item_t out_item;

  utf8_stream_validator u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  // idling percentages of the current phase
  int idle_pct = 0;
  int stall_pct = 0;

  int mismatch_count = 0;
  int strings_sent = 0;
  int bytes_sent = 0;
  int clean_seen = 0;
  int rejected_seen = 0;

  // verdicts still owed by the block, oldest first
  u8sv_pkg::out_item_t verdict_q[$];

  // decoder state mirrored from the accepted byte stream
  logic [1:0] seq_pending = '0;
  logic [20:0] seq_code = '0;
  logic [20:0] seq_floor = '0;
  logic err_seen = 1'b0;
  u8sv_pkg::err_kind_t err_kind = u8sv_pkg::KIND_NONE;
  logic [15:0] err_pos = '0;
  logic [15:0] byte_pos = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic void flag_error(input u8sv_pkg::err_kind_t kind);
    err_seen = 1'b1;
    err_kind = kind;
    err_pos = byte_pos;
  endfunction

  // advance the mirrored decoder by one accepted byte; queue a verdict on the last one
  function automatic void track_byte(input logic [7:0] b, input logic last);
    u8sv_pkg::out_item_t v;
    if (!err_seen) begin
      if (seq_pending != 2'd0) begin
        if (b[7:6] != u8sv_pkg::CONT_TAG) begin
          flag_error(u8sv_pkg::KIND_BAD_CONT);
        end else begin
          seq_code = {seq_code[14:0], b[5:0]};
          seq_pending = seq_pending - 2'd1;
          if (seq_pending == 2'd0) begin
            if (seq_code < seq_floor) flag_error(u8sv_pkg::KIND_OVERLONG);
            else if (seq_code > u8sv_pkg::CODE_MAX) flag_error(u8sv_pkg::KIND_ABOVE_MAX);
            else if (seq_code >= u8sv_pkg::SURR_LO && seq_code <= u8sv_pkg::SURR_HI)
              flag_error(u8sv_pkg::KIND_SURROGATE);
          end
        end
      end else if (b == 8'h00) begin
        flag_error(u8sv_pkg::KIND_ZERO);
      end else if (b > u8sv_pkg::ASCII_TOP) begin
        if (b >= u8sv_pkg::LEAD2_LO && b <= u8sv_pkg::LEAD2_HI) begin
          seq_pending = 2'd1;
          seq_code = {16'd0, b[4:0]};
          seq_floor = u8sv_pkg::MIN_2B;
        end else if (b >= u8sv_pkg::LEAD3_LO && b <= u8sv_pkg::LEAD3_HI) begin
          seq_pending = 2'd2;
          seq_code = {17'd0, b[3:0]};
          seq_floor = u8sv_pkg::MIN_3B;
        end else if (b >= u8sv_pkg::LEAD4_LO && b <= u8sv_pkg::LEAD4_HI) begin
          seq_pending = 2'd3;
          seq_code = {18'd0, b[2:0]};
          seq_floor = u8sv_pkg::MIN_4B;
        end else begin
          flag_error(u8sv_pkg::KIND_BAD_LEAD);
        end
      end
    end
    if (last && !err_seen && seq_pending != 2'd0) flag_error(u8sv_pkg::KIND_TRUNCATED);
    if (!last) begin
      byte_pos = byte_pos + 16'd1;
    end else begin
      v.valid_res = !err_seen;
      v.error_kind = err_seen ? err_kind : u8sv_pkg::KIND_NONE;
      v.error_position = err_seen ? err_pos : 16'd0;
      verdict_q.push_back(v);
      seq_pending = '0;
      seq_code = '0;
      seq_floor = '0;
      err_seen = 1'b0;
      err_kind = u8sv_pkg::KIND_NONE;
      err_pos = '0;
      byte_pos = '0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{data_byte: b, last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_byte(b, last);
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_string(input byte_str_t s);
    foreach (s[k]) send_byte(s[k], k == s.size() - 1);
  endtask

  // append cp in a len-byte utf-8 form; overlong and out-of-range forms are allowed
  function automatic void add_code(inout byte_str_t s, input logic [20:0] cp, input int len);
    case (len)
      1: s.push_back(cp[7:0]);
      2: begin
        s.push_back({3'b110, cp[10:6]});
        s.push_back({2'b10, cp[5:0]});
      end
      3: begin
        s.push_back({4'b1110, cp[15:12]});
        s.push_back({2'b10, cp[11:6]});
        s.push_back({2'b10, cp[5:0]});
      end
      default: begin
        s.push_back({5'b11110, cp[20:18]});
        s.push_back({2'b10, cp[17:12]});
        s.push_back({2'b10, cp[11:6]});
        s.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_valid_code(input int len);
    logic [20:0] cp;
    case (len)
      2: cp = 21'($urandom_range('h80, 'h7ff));
      3: begin
        cp = 21'($urandom_range('h800, 'hffff));
        if (cp >= u8sv_pkg::SURR_LO && cp <= u8sv_pkg::SURR_HI) cp = cp ^ 21'h04000;
      end
      default: cp = 21'($urandom_range('h10000, 'h10ffff));
    endcase
    return cp;
  endfunction

  // mostly well-formed characters, with a sprinkling of each way a sequence can break
  function automatic void build_random_string(output byte_str_t s);
    int units;
    int pick;
    int len;
    int k;
    logic [7:0] b;
    s = {};
    units = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    repeat (units) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(2, 4);
      if (pick < 28) begin
        add_code(s, 21'($urandom_range(1, 127)), 1);
      end else if (pick < 46) begin
        add_code(s, pick_valid_code(2), 2);
      end else if (pick < 64) begin
        add_code(s, pick_valid_code(3), 3);
      end else if (pick < 80) begin
        add_code(s, pick_valid_code(4), 4);
      end else if (pick < 83) begin
        add_code(s, 21'($urandom_range(0, len == 2 ? 'h7f : (len == 3 ? 'h7ff : 'hffff))),
                 len);
      end else if (pick < 85) begin
        add_code(s, 21'($urandom_range(u8sv_pkg::SURR_LO, u8sv_pkg::SURR_HI)), 3);
      end else if (pick < 87) begin
        add_code(s, 21'($urandom_range('h110000, 'h1fffff)), 4);
      end else if (pick < 90) begin
        // one continuation replaced by a byte without the 10 tag
        add_code(s, pick_valid_code(len), len);
        k = $urandom_range(0, len - 2);
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == u8sv_pkg::CONT_TAG) b[6] = 1'b1;
        s[s.size() - 1 - k] = b;
      end else if (pick < 94) begin
        add_code(s, 21'($urandom_range(0, 255)), 1);
      end else if (pick < 95) begin
        add_code(s, 21'd0, 1);
      end else begin
        // sequence missing its tail
        add_code(s, pick_valid_code(len), len);
        repeat ($urandom_range(1, len - 1)) void'(s.pop_back());
      end
    end
  endfunction

  task automatic test_single_bytes();
    send_string({8'h00});
    send_string({8'h01});
    send_string({8'h7f});
    send_string({8'h80});
    send_string({8'hc1});
    send_string({8'hf5});
    send_string({8'hff});
    send_string({8'h41, 8'h00, 8'h42});
  endtask

  task automatic test_multibyte_forms();
    send_string({8'hc2, 8'h80});
    send_string({8'hdf, 8'hbf});
    send_string({8'he0, 8'ha0, 8'h80});
    send_string({8'hed, 8'h9f, 8'hbf});
    send_string({8'hef, 8'hbf, 8'hbf});
    send_string({8'hf0, 8'h90, 8'h80, 8'h80});
    send_string({8'hf4, 8'h8f, 8'hbf, 8'hbf});
  endtask

  task automatic test_range_errors();
    send_string({8'he0, 8'h9f, 8'hbf});
    send_string({8'hf0, 8'h8f, 8'hbf, 8'hbf});
    send_string({8'hf4, 8'h90, 8'h80, 8'h80});
    send_string({8'hed, 8'ha0, 8'h80});
    send_string({8'hed, 8'hbf, 8'hbf});
  endtask

  task automatic test_broken_sequences();
    send_string({8'hc2, 8'h41});
    send_string({8'he0, 8'ha0, 8'h00});
    send_string({8'hf0, 8'h90, 8'hc0, 8'h80});
    send_string({8'hc2});
    send_string({8'h41, 8'he1, 8'h80});
    send_string({8'h41, 8'hf4, 8'h8f, 8'hbf});
    // only the first error counts
    send_string({8'h80, 8'h00, 8'hc2});
  endtask

  // long strings with the first error far from the start
  task automatic test_long_strings();
    int i;
    for (i = 0; i < 120; i++) send_byte(8'($urandom_range(1, 127)), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);
    for (i = 0; i < 121; i++) send_byte(8'($urandom_range(1, 127)), 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h41, 1'b1);
    for (i = 0; i < 119; i++) send_byte(8'($urandom_range(1, 127)), 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  task automatic test_random_strings(input int gap_pct, input int hold_pct, input int n_bytes);
    byte_str_t s;
    int sent;
    idle_pct = gap_pct;
    stall_pct = hold_pct;
    sent = 0;
    while (sent < n_bytes) begin
      build_random_string(s);
      send_string(s);
      sent += s.size();
    end
  endtask

  // result side: random stall and in-order verdict check
  always @(posedge clk) begin
    u8sv_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (out_item.valid_res === 1'b1) clean_seen++;
      else rejected_seen++;
      if (verdict_q.size() == 0) begin
        note_mismatch($sformatf("unexpected verdict valid=%0b kind=%0d pos=%0d",
                                out_item.valid_res, out_item.error_kind,
                                out_item.error_position));
      end else begin
        want = verdict_q.pop_front();
        if (out_item.valid_res !== want.valid_res || out_item.error_kind !== want.error_kind ||
            out_item.error_position !== want.error_position)
          note_mismatch($sformatf({"expected valid=%0b kind=%0d pos=%0d, ",
                                   "got valid=%0b kind=%0d pos=%0d"},
                                  want.valid_res, want.error_kind, want.error_position,
                                  out_item.valid_res, out_item.error_kind,
                                  out_item.error_position));
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_single_bytes();
    test_multibyte_forms();
    test_range_errors();
    test_broken_sequences();
    test_long_strings();
    test_random_strings(0, 0, 350);
    test_random_strings(56, 0, 350);
    test_random_strings(0, 56, 350);
    test_random_strings(23, 23, 350);

    in_valid <= 1'b0;
    waited = 0;
    while (verdict_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (verdict_q.size() != 0)
      note_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));

    $display("sent %0d strings (%0d bytes) incl. long strings and all error kinds",
             strings_sent, bytes_sent);
    $display("verdicts seen: %0d clean, %0d rejected", clean_seen, rejected_seen);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
